// ----- rtl/spsg_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the step/direction generator.
// No dependencies; used by every module of the block.
package spsg_pkg;

	// default widths of the parameterised stores
	localparam int POSITION_BITS_DEF = 16;
	localparam int INTERVAL_BITS_DEF = 32;

	// field widths
	localparam int OP_W      = 3;
	localparam int TARGET_W  = 16;
	localparam int VEL_W     = 17;
	localparam int CHG_W     = 18;
	localparam int RATE_W    = 16;
	localparam int TICK_W    = 27;
	localparam int TOP_W     = 32;
	localparam int OPEN_W    = 15;
	localparam int OUT_POS_W = 16;
	localparam int OUT_IV_W  = 32;
	localparam int EXT_W     = 32;   // common width for zero-extended compares
	localparam int DIVR_W    = 17;   // divisor 2*|v| and remainder width
	localparam int DIV_STEPS = TICK_W;

	// APB
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	// operation codes
	localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
	localparam logic [OP_W-1:0] OP_MOVE   = 3'd1;
	localparam logic [OP_W-1:0] OP_STOP   = 3'd2;
	localparam logic [OP_W-1:0] OP_OPEN   = 3'd3;
	localparam logic [OP_W-1:0] OP_CLOSED = 3'd4;

	// register indexes
	localparam logic [2:0] REG_MAX_VEL  = 3'd0;
	localparam logic [2:0] REG_MAX_CHG  = 3'd1;
	localparam logic [2:0] REG_CTRL     = 3'd2;
	localparam logic [2:0] REG_TICK     = 3'd3;
	localparam logic [2:0] REG_TOP      = 3'd4;
	localparam logic [2:0] REG_OPEN     = 3'd5;

	typedef struct packed {
		logic [RATE_W-1:0] vel_limit;
		logic [RATE_W-1:0] vel_change_limit;
		logic [RATE_W-1:0] control_rate;
		logic [TICK_W-1:0] tick_rate;
		logic [TOP_W-1:0]  counter_top;
		logic [OPEN_W-1:0] open_position;
	} spsg_cfg_t;

	// result item, last field in the lowest bits
	typedef struct packed {
		logic                    pad;
		logic                    running;
		logic                    direction_level;
		logic                    pulse_level;
		logic [OUT_IV_W-1:0]     pulse_interval;
		logic signed [CHG_W-1:0] velocity_change;
		logic signed [VEL_W-1:0] velocity;
		logic [OUT_POS_W-1:0]    position;
		logic                    status;
	} spsg_out_t;

	typedef struct packed {
		logic exec;      // operation on the accepted item, other than a move
		logic mul;       // latch error * control rate
		logic limit;     // apply change limit
		logic clamp;     // apply velocity clamp, load divider
		logic div_step;  // one quotient bit
		logic commit;    // write back move results
	} spsg_cmd_t;

	typedef struct packed {
		logic vel_zero;
	} spsg_sts_t;

endpackage

// ----- rtl/spsg_regs.sv -----
`timescale 1ns / 1ps
// APB configuration registers of the step generator.
// Depends on spsg_pkg.
module spsg_regs (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [spsg_pkg::ADDR_W-1:0] paddr,
	input  logic [spsg_pkg::DATA_W-1:0] pwdata,
	output logic [spsg_pkg::DATA_W-1:0] prdata,
	output spsg_pkg::spsg_cfg_t       cfg
);
	import spsg_pkg::*;

	spsg_cfg_t  cfg_q;
	logic [2:0] idx;
	logic       wr_en;

	assign idx   = paddr[ADDR_W-1:2];
	assign wr_en = psel & penable & pwrite;
	assign cfg   = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.vel_limit        <= RATE_W'(20000);
			cfg_q.vel_change_limit <= RATE_W'(1066);
			cfg_q.control_rate     <= RATE_W'(1000);
			cfg_q.tick_rate        <= TICK_W'(1000000);
			cfg_q.counter_top      <= '1;
			cfg_q.open_position    <= OPEN_W'(8000);
		end else if (wr_en) begin
			case (idx)
				REG_MAX_VEL: cfg_q.vel_limit        <= pwdata[RATE_W-1:0];
				REG_MAX_CHG: cfg_q.vel_change_limit <= pwdata[RATE_W-1:0];
				REG_CTRL:    cfg_q.control_rate     <= pwdata[RATE_W-1:0];
				REG_TICK:    cfg_q.tick_rate        <= pwdata[TICK_W-1:0];
				REG_TOP:     cfg_q.counter_top      <= pwdata[TOP_W-1:0];
				REG_OPEN:    cfg_q.open_position    <= pwdata[OPEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_MAX_VEL: prdata = DATA_W'(cfg_q.vel_limit);
			REG_MAX_CHG: prdata = DATA_W'(cfg_q.vel_change_limit);
			REG_CTRL:    prdata = DATA_W'(cfg_q.control_rate);
			REG_TICK:    prdata = DATA_W'(cfg_q.tick_rate);
			REG_TOP:     prdata = DATA_W'(cfg_q.counter_top);
			REG_OPEN:    prdata = DATA_W'(cfg_q.open_position);
			default:     prdata = '0;
		endcase
	end

endmodule

// ----- rtl/spsg_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer of the step generator: handshakes and move command steps.
// Depends on spsg_pkg.
module spsg_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [spsg_pkg::OP_W-1:0] op,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output spsg_pkg::spsg_cmd_t       cmd,
	input  spsg_pkg::spsg_sts_t       sts
);
	import spsg_pkg::*;

	localparam int CNT_W = $clog2(DIV_STEPS);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_LIMIT = 5'b00010,
		ST_CLAMP = 5'b00100,
		ST_DIV   = 5'b01000,
		ST_CAP   = 5'b10000
	} state_t;

	state_t           state_q, state_nxt;
	logic [CNT_W-1:0] cnt_q;
	logic             valid_q;
	logic             accept;

	assign s_tready = (state_q == ST_IDLE) && (!valid_q || m_tready);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = valid_q;

	always_comb begin
		state_nxt    = state_q;
		cmd          = '0;
		cmd.exec     = accept && (op != OP_MOVE);
		cmd.mul      = accept && (op == OP_MOVE);
		case (state_q)
			ST_IDLE: begin
				if (cmd.mul)
					state_nxt = ST_LIMIT;
			end
			ST_LIMIT: begin
				cmd.limit = 1'b1;
				state_nxt = ST_CLAMP;
			end
			ST_CLAMP: begin
				cmd.clamp = 1'b1;
				state_nxt = ST_DIV;
			end
			ST_DIV: begin
				if (sts.vel_zero) begin
					state_nxt = ST_CAP;
				end else begin
					cmd.div_step = 1'b1;
					if (cnt_q == CNT_W'(DIV_STEPS - 1))
						state_nxt = ST_CAP;
				end
			end
			ST_CAP: begin
				cmd.commit = 1'b1;
				state_nxt  = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.clamp)
				cnt_q <= '0;
			else if (cmd.div_step)
				cnt_q <= cnt_q + 1'b1;
			if (cmd.exec || cmd.commit)
				valid_q <= 1'b1;
			else if (m_tready)
				valid_q <= 1'b0;
		end
	end

endmodule

// ----- rtl/spsg_dp.sv -----
`timescale 1ns / 1ps
// Datapath of the step generator: motion state, velocity arithmetic,
// serial interval divider and result register. Depends on spsg_pkg.
module spsg_dp #(
	parameter int POSITION_BITS = spsg_pkg::POSITION_BITS_DEF,
	parameter int INTERVAL_BITS = spsg_pkg::INTERVAL_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  spsg_pkg::spsg_cfg_t           cfg,
	input  spsg_pkg::spsg_cmd_t           cmd,
	output spsg_pkg::spsg_sts_t           sts,
	input  logic [spsg_pkg::OP_W-1:0]     op,
	input  logic [spsg_pkg::TARGET_W-1:0] target,
	output spsg_pkg::spsg_out_t           res
);
	import spsg_pkg::*;

	localparam int ERR_W  = ((POSITION_BITS > TARGET_W) ? POSITION_BITS : TARGET_W) + 1;
	localparam int PROD_W = ERR_W + RATE_W + 1;

	// motion state
	logic [POSITION_BITS-1:0] pos_q, n_pos;
	logic signed [VEL_W-1:0]  vel_q, n_vel;
	logic signed [CHG_W-1:0]  chg_q, n_chg;
	logic [INTERVAL_BITS-1:0] iv_q, n_iv;
	logic [INTERVAL_BITS-1:0] tc_q, n_tc;
	logic                     pulse_q, n_pulse;
	logic                     dir_q, n_dir;
	logic                     run_q, n_run;
	logic                     n_status;

	// move sequence
	logic signed [PROD_W-1:0] prod_q, lim_q;
	logic signed [VEL_W-1:0]  vel_new_q;
	logic signed [CHG_W-1:0]  chg_new_q;
	logic [DIVR_W-1:0]        div_d_q, div_r_q;
	logic [TICK_W-1:0]        div_q_q;

	spsg_out_t res_q;

	// multiply
	logic signed [ERR_W-1:0]  err;
	logic signed [RATE_W:0]   rate_s;
	always_comb begin
		err = $signed({{(ERR_W-TARGET_W){target[TARGET_W-1]}}, target})
		    - $signed({{(ERR_W-POSITION_BITS){pos_q[POSITION_BITS-1]}}, pos_q});
		rate_s = $signed({1'b0, cfg.control_rate});
	end

	// change limit
	logic signed [PROD_W:0] diff, lim_ext, cur_ext, lim_val;
	always_comb begin
		cur_ext = {{(PROD_W+1-VEL_W){vel_q[VEL_W-1]}}, vel_q};
		lim_ext = $signed({{(PROD_W+1-RATE_W){1'b0}}, cfg.vel_change_limit});
		diff    = {prod_q[PROD_W-1], prod_q} - cur_ext;
		if (diff > lim_ext)
			lim_val = cur_ext + lim_ext;
		else if (diff < -lim_ext)
			lim_val = cur_ext - lim_ext;
		else
			lim_val = {prod_q[PROD_W-1], prod_q};
	end

	// velocity clamp
	logic signed [PROD_W-1:0] vmax_ext, clamp_val;
	logic signed [VEL_W-1:0]  vel_c, vel_abs;
	always_comb begin
		vmax_ext = $signed({{(PROD_W-RATE_W){1'b0}}, cfg.vel_limit});
		if (lim_q > vmax_ext)
			clamp_val = vmax_ext;
		else if (lim_q < -vmax_ext)
			clamp_val = -vmax_ext;
		else
			clamp_val = lim_q;
		vel_c   = clamp_val[VEL_W-1:0];
		vel_abs = vel_c[VEL_W-1] ? -vel_c : vel_c;
	end

	// restoring divider step
	logic [DIVR_W:0]   div_sh;
	logic [DIVR_W+1:0] div_sub;
	always_comb begin
		div_sh  = {div_r_q, div_q_q[TICK_W-1]};
		div_sub = {1'b0, div_sh} - {2'b00, div_d_q};
	end

	// interval cap
	logic [INTERVAL_BITS-1:0] cap, iv_cap;
	always_comb begin
		cap = cfg.counter_top[INTERVAL_BITS-1:0];
		if ((vel_new_q == '0) || (EXT_W'(div_q_q) > EXT_W'(cap)))
			iv_cap = cap;
		else
			iv_cap = div_q_q[INTERVAL_BITS-1:0];
	end

	assign sts.vel_zero = (vel_new_q == '0);

	// next motion state
	logic [INTERVAL_BITS-1:0] tc_inc;
	logic                     wrong_dir;
	logic [EXT_W-1:0]         open_ext;
	always_comb begin
		tc_inc    = tc_q + 1'b1;
		wrong_dir = (dir_q && !vel_q[VEL_W-1] && (vel_q != '0)) || (!dir_q && vel_q[VEL_W-1]);
		open_ext  = EXT_W'(cfg.open_position);
		n_pos     = pos_q;
		n_vel     = vel_q;
		n_chg     = chg_q;
		n_iv      = iv_q;
		n_tc      = tc_q;
		n_pulse   = pulse_q;
		n_dir     = dir_q;
		n_run     = run_q;
		n_status  = 1'b0;
		if (cmd.commit) begin
			n_vel = vel_new_q;
			n_chg = chg_new_q;
			n_iv  = iv_cap;
			n_tc  = '0;
			n_run = 1'b1;
		end else begin
			case (op)
				OP_TICK: begin
					if (run_q) begin
						if (tc_inc >= iv_q) begin
							n_tc = '0;
							if (wrong_dir) begin
								n_dir = ~dir_q;
							end else begin
								if (pulse_q)
									n_pos = dir_q ? pos_q - 1'b1 : pos_q + 1'b1;
								n_pulse = ~pulse_q;
							end
						end else begin
							n_tc = tc_inc;
						end
					end
				end
				OP_STOP: begin
					n_run = 1'b0;
					n_vel = '0;
					n_chg = '0;
					n_tc  = '0;
				end
				OP_OPEN: begin
					if (run_q)
						n_status = 1'b1;
					else
						n_pos = open_ext[POSITION_BITS-1:0];
				end
				OP_CLOSED: begin
					if (run_q)
						n_status = 1'b1;
					else
						n_pos = '0;
				end
				default: ;
			endcase
		end
	end

	logic [EXT_W-1:0] pos_ext;
	assign pos_ext = EXT_W'(n_pos);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			vel_q   <= '0;
			chg_q   <= '0;
			iv_q    <= '0;
			tc_q    <= '0;
			pulse_q <= 1'b0;
			dir_q   <= 1'b0;
			run_q   <= 1'b0;
		end else if (cmd.exec || cmd.commit) begin
			pos_q   <= n_pos;
			vel_q   <= n_vel;
			chg_q   <= n_chg;
			iv_q    <= n_iv;
			tc_q    <= n_tc;
			pulse_q <= n_pulse;
			dir_q   <= n_dir;
			run_q   <= n_run;
		end
	end

	// sequence and result registers carry payload only
	always_ff @(posedge clk) begin
		if (cmd.mul)
			prod_q <= PROD_W'(err * rate_s);
		if (cmd.limit)
			lim_q <= lim_val[PROD_W-1:0];
		if (cmd.clamp) begin
			vel_new_q <= vel_c;
			chg_new_q <= CHG_W'(vel_c) - CHG_W'(vel_q);
			div_d_q   <= {vel_abs[VEL_W-2:0], 1'b0};
			div_r_q   <= '0;
			div_q_q   <= cfg.tick_rate;
		end else if (cmd.div_step) begin
			if (!div_sub[DIVR_W+1]) begin
				div_r_q <= div_sub[DIVR_W-1:0];
				div_q_q <= {div_q_q[TICK_W-2:0], 1'b1};
			end else begin
				div_r_q <= div_sh[DIVR_W-1:0];
				div_q_q <= {div_q_q[TICK_W-2:0], 1'b0};
			end
		end
		if (cmd.exec || cmd.commit) begin
			res_q.pad             <= 1'b0;
			res_q.running         <= n_run;
			res_q.direction_level <= n_dir;
			res_q.pulse_level     <= n_pulse;
			res_q.pulse_interval  <= OUT_IV_W'(n_iv);
			res_q.velocity_change <= n_chg;
			res_q.velocity        <= n_vel;
			res_q.position        <= pos_ext[OUT_POS_W-1:0];
			res_q.status          <= n_status;
		end
	end

	assign res = res_q;

endmodule

// ----- rtl/stepper_position_step_generator_core.sv -----
`timescale 1ns / 1ps
// Step/direction generator core. Tick, stop and preset: result valid the next cycle.
// Move: multiply, limit, clamp, 27-step serial divide, cap, then result valid;
// the divide steps are skipped when the new velocity is zero.
// One item in flight; a new item is taken when the result register is free or draining.
// arst_n asynchronously clears motion state, sequencer and valid; registers take defaults.
module stepper_position_step_generator_core #(
	parameter int POSITION_BITS = spsg_pkg::POSITION_BITS_DEF,
	parameter int INTERVAL_BITS = spsg_pkg::INTERVAL_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// command stream
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [15:0]                 s_tdata,  // [15:0] target_position
	input  logic [2:0]                  s_tuser,  // [2:0] operation
	// result stream
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// [0] status, [16:1] position, [33:17] velocity, [51:34] velocity_change,
	// [83:52] pulse_interval, [84] pulse_level, [85] direction_level, [86] running, [87] 0
	output logic [87:0]                 m_tdata,
	// configuration
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [spsg_pkg::ADDR_W-1:0] paddr,
	input  logic [spsg_pkg::DATA_W-1:0] pwdata,
	output logic [spsg_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);
	import spsg_pkg::*;

	spsg_cfg_t cfg;
	spsg_cmd_t cmd;
	spsg_sts_t sts;
	spsg_out_t res;

	// zero wait states on the register port
	assign pready = 1'b1;

	spsg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// sequencer: accepts a transaction, runs tick, stop and preset ops at once and
	// steps a move through its arithmetic, then raises m_tvalid
	spsg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.op       (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	// datapath: state, arithmetic and result register; the op and target
	// are only sampled in the accept cycle
	spsg_dp #(
		.POSITION_BITS (POSITION_BITS),
		.INTERVAL_BITS (INTERVAL_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cmd    (cmd),
		.sts    (sts),
		.op     (s_tuser),
		.target (s_tdata),
		.res    (res)
	);

	assign m_tdata = res;

endmodule

// ----- rtl/spsg_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the step generator core, bound to the top level.
// Depends on spsg_pkg.
module spsg_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [2:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [87:0] m_tdata
);
	import spsg_pkg::*;

	spsg_out_t r;
	assign r = m_tdata;

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// no new transaction while an untaken result waits
	a_block: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input taken over a waiting result");

	// a stop gives a stopped result with zero velocity in the next cycle
	a_stop: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == OP_STOP)
		|=> m_tvalid && !r.running && (r.velocity == '0) && (r.velocity_change == '0))
		else $error("stop result wrong");

	// a rejected preset only while running
	a_reject: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && r.status |-> r.running)
		else $error("preset rejected while stopped");

endmodule

bind stepper_position_step_generator_core spsg_checker u_chk (.*);
